// ----- hdl/bpb_pkg.sv -----
// Shared types and constants of the branch predictor bank.
package bpb_pkg;

    localparam int TABLE_INDEX_W = 10;
    localparam int TARGET_W      = 32;
    localparam int TOTAL_W       = 32;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 200;
    localparam int INDEX_HALF_W  = 5;

    localparam logic [1:0] CTR_MIN        = 2'd0;
    localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [1:0] CTR_MAX        = 2'd3;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [1:0]          ctr;
        logic                one_bit;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{target: '0, ctr: CTR_WEAK_TAKEN, one_bit: 1'b1};

    // Packed so that the static predictor lands in bit 0.
    typedef struct packed {
        logic btb_hit;
        logic two_bit_hit;
        logic one_bit_hit;
        logic global_hit;
        logic static_hit;
    } t_hits;

endpackage

// ----- hdl/branch_predictor_bank.sv -----
// Top level of the branch predictor bank: table memory pipeline and running totals.
//
// Usage:
//   Input beats on s_axis carry one resolved branch each: table index, target
//   and outcome. Output beats on m_axis carry the five hit flags of the static,
//   last-outcome, one-bit, two-bit and target-buffer predictors and the six
//   running 32-bit totals, which wrap.
//   One beat is accepted every cycle. A result passes through the table memory
//   read, then through scoring, training and the output register. The rate is
//   set by the table memory, which is read once and written once per branch;
//   a branch that reads an entry the previous branch writes in the same cycle
//   takes the written value through a forwarding register.
//   After reset the table memory is swept to its initial contents, one entry
//   per cycle over all TABLE_ENTRIES entries; s_axis_tready stays low meanwhile.
//   Totals restart at zero and the last outcome at taken.
//   When m_axis_tready is low the output register holds its beat; one more
//   branch can wait in the scoring stage, after which s_axis_tready drops.
module branch_predictor_bank #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // table_index[9:0], branch_target[41:10], branch_taken[42], zero pad
    input  logic [bpb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // static_hit[0], global_hit[1], one_bit_hit[2], two_bit_hit[3], btb_hit[4],
    // branch_total[36:5], static_total[68:37], global_total[100:69],
    // one_bit_total[132:101], two_bit_total[164:133], btb_total[196:165], zero pad
    output logic [bpb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import bpb_pkg::*;

    localparam int IW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ENTRY_W = $bits(t_entry);
    localparam int PAD_W   = OUT_TDATA_W - 5 - 6 * TOTAL_W;

    // Input fields.
    logic [TABLE_INDEX_W-1:0] in_table_index;
    logic [TARGET_W-1:0]      in_branch_target;
    logic                     in_branch_taken;
    logic [IW-1:0]            in_idx;
    logic                     in_fire;

    // Clearing sweep.
    logic          r_clr_active;
    logic [IW-1:0] r_clr_addr;

    // Scoring stage.
    logic                r_s1_valid;
    logic [IW-1:0]       r_s1_idx;
    logic [TARGET_W-1:0] r_s1_target;
    logic                r_s1_taken;
    logic                r_s1_fwd;
    t_entry              r_s1_fwd_entry;
    logic                s1_fire;
    t_entry              s1_entry;
    t_entry              new_entry;
    t_hits               hits;

    // Memory ports.
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    // Running state.
    logic               r_last_outcome;
    logic [TOTAL_W-1:0] r_branch_cnt, n_branch_cnt;
    logic [TOTAL_W-1:0] r_static_cnt, n_static_cnt;
    logic [TOTAL_W-1:0] r_global_cnt, n_global_cnt;
    logic [TOTAL_W-1:0] r_one_cnt, n_one_cnt;
    logic [TOTAL_W-1:0] r_two_cnt, n_two_cnt;
    logic [TOTAL_W-1:0] r_btb_cnt, n_btb_cnt;

    // Output register.
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata;
    logic [OUT_TDATA_W-1:0] n_out_tdata;
    logic                   out_ready;

    assign in_table_index   = s_axis_tdata[TABLE_INDEX_W-1:0];
    assign in_branch_target = s_axis_tdata[TABLE_INDEX_W +: TARGET_W];
    assign in_branch_taken  = s_axis_tdata[TABLE_INDEX_W + TARGET_W];

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && out_ready;
    assign s_axis_tready = !r_clr_active && (!r_s1_valid || s1_fire);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    bpb_index #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_index (
        .i_table_index(in_table_index),
        .o_index      (in_idx)
    );

    always_comb begin
        if (r_clr_active) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = ENTRY_RESET;
        end else begin
            ram_we    = s1_fire;
            ram_waddr = r_s1_idx;
            ram_wdata = new_entry;
        end
    end

    bpb_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (in_fire),
        .i_raddr(in_idx),
        .o_rdata(ram_rdata)
    );

    // The read issued in the same cycle as a write to that entry returns
    // stale data, so the written entry is carried along instead.
    assign s1_entry = r_s1_fwd ? r_s1_fwd_entry : t_entry'(ram_rdata);

    bpb_update u_update (
        .i_entry        (s1_entry),
        .i_branch_target(r_s1_target),
        .i_branch_taken (r_s1_taken),
        .i_last_outcome (r_last_outcome),
        .o_hits         (hits),
        .o_entry        (new_entry)
    );

    always_comb begin
        n_branch_cnt = r_branch_cnt + TOTAL_W'(1);
        n_static_cnt = r_static_cnt + TOTAL_W'(hits.static_hit);
        n_global_cnt = r_global_cnt + TOTAL_W'(hits.global_hit);
        n_one_cnt    = r_one_cnt + TOTAL_W'(hits.one_bit_hit);
        n_two_cnt    = r_two_cnt + TOTAL_W'(hits.two_bit_hit);
        n_btb_cnt    = r_btb_cnt + TOTAL_W'(hits.btb_hit);
        n_out_tdata  = {{PAD_W{1'b0}}, n_btb_cnt, n_two_cnt, n_one_cnt, n_global_cnt,
                        n_static_cnt, n_branch_cnt, hits};
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active   <= 1'b1;
            r_clr_addr     <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_last_outcome <= 1'b1;
            r_branch_cnt   <= '0;
            r_static_cnt   <= '0;
            r_global_cnt   <= '0;
            r_one_cnt      <= '0;
            r_two_cnt      <= '0;
            r_btb_cnt      <= '0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + IW'(1);
                if (r_clr_addr == IW'(TABLE_ENTRIES - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid    <= 1'b1;
                r_last_outcome <= r_s1_taken;
                r_branch_cnt   <= n_branch_cnt;
                r_static_cnt   <= n_static_cnt;
                r_global_cnt   <= n_global_cnt;
                r_one_cnt      <= n_one_cnt;
                r_two_cnt      <= n_two_cnt;
                r_btb_cnt      <= n_btb_cnt;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_idx       <= in_idx;
            r_s1_target    <= in_branch_target;
            r_s1_taken     <= in_branch_taken;
            r_s1_fwd       <= s1_fire && (r_s1_idx == in_idx);
            r_s1_fwd_entry <= new_entry;
        end
        if (s1_fire) begin
            r_out_tdata <= n_out_tdata;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;

    a_no_work_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> (!r_s1_valid && !r_out_valid))
        else $error("pipeline holds a branch during the table sweep");

    a_stalled_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> (r_s1_valid && $stable(r_s1_idx) && $stable(r_s1_fwd)))
        else $error("scoring stage changed while stalled");

    a_branch_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (r_out_valid && (r_branch_cnt == $past(r_branch_cnt) + TOTAL_W'(1))))
        else $error("branch total did not advance by one");

    a_count_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_fire |=> $stable(r_branch_cnt) && $stable(r_last_outcome))
        else $error("running state changed without a scored branch");

endmodule

// ----- hdl/bpb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bpb_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bpb_index.sv -----
// Reduces the incoming table index modulo the table size.
module bpb_index #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic [bpb_pkg::TABLE_INDEX_W-1:0]                             i_table_index,
    output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] o_index
);
    import bpb_pkg::*;

    localparam int IW       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TAB_SIZE = 1 << INDEX_HALF_W;

    typedef logic [IW-1:0] t_mod_tab [TAB_SIZE];

    // Residue of (k * scale) for every value of one index half.
    function automatic t_mod_tab build_tab(input int scale);
        t_mod_tab tab;
        for (int k = 0; k < TAB_SIZE; k++) begin
            tab[k] = IW'((k * scale) % TABLE_ENTRIES);
        end
        return tab;
    endfunction

    localparam t_mod_tab HI_MOD = build_tab(TAB_SIZE);
    localparam t_mod_tab LO_MOD = build_tab(1);
    localparam logic [IW:0] ENTRIES_EXT = (IW + 1)'(TABLE_ENTRIES);

    logic [IW:0] part_sum;

    // Both residues are below the table size, so one subtraction finishes it.
    always_comb begin
        part_sum = {1'b0, HI_MOD[i_table_index[TABLE_INDEX_W-1:INDEX_HALF_W]]}
                 + {1'b0, LO_MOD[i_table_index[INDEX_HALF_W-1:0]]};
        if (part_sum >= ENTRIES_EXT) begin
            o_index = IW'(part_sum - ENTRIES_EXT);
        end else begin
            o_index = part_sum[IW-1:0];
        end
    end

endmodule

// ----- hdl/bpb_update.sv -----
// Scores one branch against a table entry and computes the trained entry.
module bpb_update (
    input  bpb_pkg::t_entry               i_entry,
    input  logic [bpb_pkg::TARGET_W-1:0] i_branch_target,
    input  logic                          i_branch_taken,
    input  logic                          i_last_outcome,
    output bpb_pkg::t_hits                o_hits,
    output bpb_pkg::t_entry               o_entry
);
    import bpb_pkg::*;

    always_comb begin
        o_hits.static_hit  = i_branch_taken;
        o_hits.global_hit  = (i_last_outcome == i_branch_taken);
        o_hits.one_bit_hit = (i_entry.one_bit == i_branch_taken);
        o_hits.two_bit_hit = ((i_entry.ctr >= CTR_WEAK_TAKEN) == i_branch_taken);
        o_hits.btb_hit     = (i_entry.target == i_branch_target);

        o_entry.one_bit = i_branch_taken;
        if (i_branch_taken) begin
            o_entry.ctr = (i_entry.ctr == CTR_MAX) ? CTR_MAX : i_entry.ctr + 2'd1;
        end else begin
            o_entry.ctr = (i_entry.ctr == CTR_MIN) ? CTR_MIN : i_entry.ctr - 2'd1;
        end
        // On a hit the stored target already equals the new one.
        o_entry.target = o_hits.btb_hit ? i_entry.target : i_branch_target;
    end

endmodule
